FILE: hw/rtl/mcb_pkg.sv
// Shared types and codes for the maze carver: field widths, microcode word layout,
// sequencer step addresses, action and jump codes, status and cell codes.
// No dependencies.
package mcb_pkg;

    localparam int X_W      = 7;
    localparam int Y_W      = 5;
    localparam int RAND_W   = 8;
    localparam int STAT_W   = 3;
    localparam int GCOLS_W  = 8;
    localparam int GROWS_W  = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b1;
    localparam logic [GCOLS_W-1:0] GRID_COLS_RST = 8'd80;
    localparam logic [GROWS_W-1:0] GRID_ROWS_RST = 6'd21;

    typedef logic [STAT_W-1:0] t_status;
    localparam t_status ST_STARTED     = 3'd0;
    localparam t_status ST_CARVED      = 3'd1;
    localparam t_status ST_BACKTRACKED = 3'd2;
    localparam t_status ST_FINISHED    = 3'd3;
    localparam t_status ST_OVERFLOW    = 3'd4;
    localparam t_status ST_NOWALK      = 3'd5;

    typedef logic [1:0] t_cell;
    localparam t_cell CELL_OPEN = 2'd0;
    localparam t_cell CELL_WALL = 2'd1;
    localparam t_cell CELL_ROOM = 2'd2;

    typedef logic [1:0] t_dir;
    localparam t_dir DIR_N = 2'd0;
    localparam t_dir DIR_E = 2'd1;
    localparam t_dir DIR_S = 2'd2;
    localparam t_dir DIR_W = 2'd3;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;
    localparam t_upc U_IDLE   = 4'd0;
    localparam t_upc U_START  = 4'd1;
    localparam t_upc U_FILL   = 4'd2;
    localparam t_upc U_MARK   = 4'd3;
    localparam t_upc U_STEP   = 4'd4;
    localparam t_upc U_RD2    = 4'd5;
    localparam t_upc U_PICK   = 4'd6;
    localparam t_upc U_CARVE  = 4'd7;
    localparam t_upc U_BACK   = 4'd8;
    localparam t_upc U_POP    = 4'd9;
    localparam t_upc U_FIN    = 4'd10;
    localparam t_upc U_NOWALK = 4'd11;
    localparam t_upc U_WAIT   = 4'd12;

    typedef logic [3:0] t_act;
    localparam t_act A_NONE  = 4'd0;
    localparam t_act A_INIT  = 4'd1;
    localparam t_act A_FILL  = 4'd2;
    localparam t_act A_MARK  = 4'd3;
    localparam t_act A_RDA   = 4'd4;
    localparam t_act A_RDB   = 4'd5;
    localparam t_act A_WALL  = 4'd6;
    localparam t_act A_CARVE = 4'd7;
    localparam t_act A_POPRD = 4'd8;
    localparam t_act A_POPLD = 4'd9;
    localparam t_act A_HALT  = 4'd10;

    typedef logic [2:0] t_cnd;
    localparam t_cnd C_DISPATCH       = 3'd0;
    localparam t_cnd C_NEXT           = 3'd1;
    localparam t_cnd C_IF_FILL_EMPTY  = 3'd2;
    localparam t_cnd C_LOOP_FILL      = 3'd3;
    localparam t_cnd C_IF_NONE_OPEN   = 3'd4;
    localparam t_cnd C_IF_STACK_EMPTY = 3'd5;
    localparam t_cnd C_DONE           = 3'd6;

    typedef struct packed {
        t_act    act;
        t_cnd    cnd;
        t_upc    tgt;
        logic    set_stat;
        t_status stat;
    } t_uword;

    typedef struct packed {
        logic fill_empty;
        logic fill_last;
        logic none_open;
        logic stack_empty;
        logic out_free;
    } t_cond;

endpackage

FILE: hw/rtl/mcb_useq.sv
// Microcode sequencer of the maze carver: step counter, control store and jump logic.
// Depends on mcb_pkg for the control word layout and the step and jump codes.
module mcb_useq
    import mcb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_go,
    input  t_upc   i_entry,
    input  t_cond  i_cond,
    output t_uword o_uword,
    output logic   o_ready,
    output logic   o_emit
);

    function automatic t_uword urom(input t_upc pc);
        t_uword w;
        w = '{act: A_NONE, cnd: C_DISPATCH, tgt: U_IDLE, set_stat: 1'b0, stat: ST_STARTED};
        case (pc)
            U_IDLE: begin
                w.cnd = C_DISPATCH;
            end
            U_START: begin
                w.act = A_INIT;
                w.cnd = C_IF_FILL_EMPTY;
                w.tgt = U_MARK;
            end
            U_FILL: begin
                w.act = A_FILL;
                w.cnd = C_LOOP_FILL;
                w.tgt = U_FILL;
            end
            U_MARK: begin
                w.act      = A_MARK;
                w.cnd      = C_DONE;
                w.set_stat = 1'b1;
                w.stat     = ST_STARTED;
            end
            U_STEP: begin
                w.act = A_RDA;
                w.cnd = C_NEXT;
            end
            U_RD2: begin
                w.act = A_RDB;
                w.cnd = C_NEXT;
            end
            U_PICK: begin
                w.act = A_WALL;
                w.cnd = C_IF_NONE_OPEN;
                w.tgt = U_BACK;
            end
            U_CARVE: begin
                w.act      = A_CARVE;
                w.cnd      = C_DONE;
                w.set_stat = 1'b1;
                w.stat     = ST_CARVED;
            end
            U_BACK: begin
                w.act = A_POPRD;
                w.cnd = C_IF_STACK_EMPTY;
                w.tgt = U_FIN;
            end
            U_POP: begin
                w.act      = A_POPLD;
                w.cnd      = C_DONE;
                w.set_stat = 1'b1;
                w.stat     = ST_BACKTRACKED;
            end
            U_FIN: begin
                w.act      = A_HALT;
                w.cnd      = C_DONE;
                w.set_stat = 1'b1;
                w.stat     = ST_FINISHED;
            end
            U_NOWALK: begin
                w.cnd      = C_DONE;
                w.set_stat = 1'b1;
                w.stat     = ST_NOWALK;
            end
            U_WAIT: begin
                w.cnd = C_DONE;
            end
            default: begin
                w.cnd = C_DISPATCH;
            end
        endcase
        return w;
    endfunction

    t_upc   r_upc;
    t_upc   n_upc;
    t_upc   w_inc;
    t_uword w_uw;

    assign w_uw    = urom(r_upc);
    assign w_inc   = r_upc + t_upc'(1);
    assign o_uword = w_uw;
    assign o_ready = (r_upc == U_IDLE);

    always_comb begin
        n_upc  = U_IDLE;
        o_emit = 1'b0;
        case (w_uw.cnd)
            C_DISPATCH:       n_upc = (i_go && o_ready) ? i_entry : U_IDLE;
            C_NEXT:           n_upc = w_inc;
            C_IF_FILL_EMPTY:  n_upc = i_cond.fill_empty ? w_uw.tgt : w_inc;
            C_LOOP_FILL:      n_upc = i_cond.fill_last ? w_inc : w_uw.tgt;
            C_IF_NONE_OPEN:   n_upc = i_cond.none_open ? w_uw.tgt : w_inc;
            C_IF_STACK_EMPTY: n_upc = i_cond.stack_empty ? w_uw.tgt : w_inc;
            C_DONE: begin
                o_emit = i_cond.out_free;
                n_upc  = i_cond.out_free ? U_IDLE : U_WAIT;
            end
            default:          n_upc = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

FILE: hw/rtl/maze_carver_backtracker_unit.sv
// Maze carver top level: configuration, cell store, path stack, walk datapath, result register.
// Depends on mcb_pkg and on the microcode sequencer mcb_useq.
//
// Channel  Dir  Handshake                  Payload
// cfg      in   i_cfg_we                   i_cfg_idx, i_cfg_data
// in       in   i_in_valid / o_in_stall    i_mode, i_start_x, i_start_y, i_rand_pick
// out      out  o_out_valid / i_out_stall  o_status, o_pos_x, o_pos_y, o_wall_x, o_wall_y
//
// A carving step runs STEP, RD2, PICK, CARVE; a backtracking step STEP, RD2, PICK, BACK, POP;
// a finishing step ends in FIN instead of POP; a step with no walk only reports. A start fills
// cells 2..cols-2 by 2..rows-2 when both sizes are at least 4, else skips the fill, one grid
// cell per cycle on the write port; step reads use its two read ports, two neighbors per cycle.
// Reset is synchronous; the cell store and the stack are not cleared and need no sweep.
// A finished result waits in the output register; while it is stalled the next
// transaction is taken and worked up to its final step.
module maze_carver_backtracker_unit
    import mcb_pkg::*;
#(
    parameter int MAX_COLS    = 128,
    parameter int MAX_ROWS    = 32,
    parameter int STACK_DEPTH = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [X_W-1:0]        i_start_x,
    input  logic [Y_W-1:0]        i_start_y,
    input  logic [RAND_W-1:0]     i_rand_pick,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STAT_W-1:0]     o_status,
    output logic [X_W-1:0]        o_pos_x,
    output logic [Y_W-1:0]        o_pos_y,
    output logic [X_W-1:0]        o_wall_x,
    output logic [Y_W-1:0]        o_wall_y
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int XW    = (CW > X_W) ? CW : X_W;
    localparam int YW    = (RW > Y_W) ? RW : Y_W;
    localparam int LW    = ((XW > YW) ? XW : YW) + 2;
    localparam int MAW   = CW + RW;
    localparam int CELLS = 1 << MAW;
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int SCW   = $clog2(STACK_DEPTH + 1);
    localparam logic [LW-1:0] L2 = LW'(2);
    localparam logic [LW-1:0] L3 = LW'(3);
    localparam logic [LW-1:0] L4 = LW'(4);

    function automatic logic in_band(input logic [LW-1:0] t, input logic [LW-1:0] lim);
        return (t >= L3) && ((t + L3) <= lim);
    endfunction

    function automatic t_dir pick_dir(input logic [3:0] opn, input logic [1:0] pick);
        logic [2:0] seen;
        t_dir       dir;
        seen = '0;
        dir  = DIR_N;
        for (int d = 0; d < 4; d++) begin
            if (opn[d]) begin
                if (seen == {1'b0, pick}) dir = 2'(d);
                seen = seen + 3'd1;
            end
        end
        return dir;
    endfunction

    logic [GCOLS_W-1:0] r_grid_cols;
    logic [GROWS_W-1:0] r_grid_rows;

    logic [XW-1:0]     r_cur_x, n_cur_x;
    logic [YW-1:0]     r_cur_y, n_cur_y;
    logic              r_walk, n_walk;
    logic [SCW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]     r_fx, n_fx;
    logic [RW-1:0]     r_fy, n_fy;
    t_dir              r_dir, n_dir;
    logic [XW-1:0]     r_wall_x, n_wall_x;
    logic [YW-1:0]     r_wall_y, n_wall_y;
    logic [1:0]        r_open2, n_open2;
    logic [RAND_W-1:0] r_rand, n_rand;
    t_status           r_stat, n_stat;
    t_cell             r_rd_a, r_rd_b;
    logic [MAW-1:0]    r_stk_rd;

    logic              r_out_valid;
    t_status           r_o_status;
    logic [X_W-1:0]    r_o_pos_x, r_o_wall_x;
    logic [Y_W-1:0]    r_o_pos_y, r_o_wall_y;

    t_cell             r_cell_mem  [CELLS];
    logic [MAW-1:0]    r_stack_mem [STACK_DEPTH];

    t_uword            w_uw;
    t_cond             w_cond;
    t_upc              w_entry;
    logic              w_ready, w_go, w_emit;

    logic [LW-1:0]     w_cols, w_rows, w_xe, w_ye;
    logic [LW-1:0]     w_tx [4];
    logic [LW-1:0]     w_ty [4];
    logic [3:0]        w_neg, w_ok, w_open4;
    logic [2:0]        w_n;
    logic [10:0]       w_prod;
    t_dir              w_dir;
    logic              w_none, w_full, w_fx_end, w_fy_end, w_cur_in_store;
    logic [XW-1:0]     w_wall_x, w_tgt_x;
    logic [YW-1:0]     w_wall_y, w_tgt_y;
    logic [MAW-1:0]    w_ra_a, w_ra_b, w_wa;
    logic              w_we;
    t_cell             w_wd;
    logic [SCW-1:0]    w_cnt_dec;

    mcb_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_entry (w_entry),
        .i_cond  (w_cond),
        .o_uword (w_uw),
        .o_ready (w_ready),
        .o_emit  (w_emit)
    );

    assign w_go       = i_in_valid && w_ready;
    assign o_in_stall = !w_ready;
    assign w_entry    = !i_mode ? U_START : (r_walk ? U_STEP : U_NOWALK);

    assign w_cols = (LW'(r_grid_cols) > LW'(MAX_COLS)) ? LW'(MAX_COLS) : LW'(r_grid_cols);
    assign w_rows = (LW'(r_grid_rows) > LW'(MAX_ROWS)) ? LW'(MAX_ROWS) : LW'(r_grid_rows);
    assign w_xe   = LW'(r_cur_x);
    assign w_ye   = LW'(r_cur_y);

    always_comb begin
        w_tx[DIR_N] = w_xe;       w_ty[DIR_N] = w_ye - L2;  w_neg[DIR_N] = (w_ye < L2);
        w_tx[DIR_E] = w_xe + L2;  w_ty[DIR_E] = w_ye;       w_neg[DIR_E] = 1'b0;
        w_tx[DIR_S] = w_xe;       w_ty[DIR_S] = w_ye + L2;  w_neg[DIR_S] = 1'b0;
        w_tx[DIR_W] = w_xe - L2;  w_ty[DIR_W] = w_ye;       w_neg[DIR_W] = (w_xe < L2);
        for (int d = 0; d < 4; d++) begin
            w_ok[d] = !w_neg[d] && in_band(w_tx[d], w_cols) && in_band(w_ty[d], w_rows);
        end
    end

    assign w_ra_a = (w_uw.act == A_RDA) ? {w_ty[DIR_N][RW-1:0], w_tx[DIR_N][CW-1:0]}
                                         : {w_ty[DIR_S][RW-1:0], w_tx[DIR_S][CW-1:0]};
    assign w_ra_b = (w_uw.act == A_RDA) ? {w_ty[DIR_E][RW-1:0], w_tx[DIR_E][CW-1:0]}
                                         : {w_ty[DIR_W][RW-1:0], w_tx[DIR_W][CW-1:0]};

    assign w_open4 = {w_ok[DIR_W] && (r_rd_b == CELL_OPEN),
                      w_ok[DIR_S] && (r_rd_a == CELL_OPEN), r_open2};
    assign w_n     = 3'(w_open4[0]) + 3'(w_open4[1]) + 3'(w_open4[2]) + 3'(w_open4[3]);
    assign w_none  = (w_open4 == 4'b0000);
    assign w_prod  = 11'(r_rand) * 11'(w_n);
    assign w_dir   = pick_dir(w_open4, w_prod[9:8]);

    always_comb begin
        w_wall_x = r_cur_x;
        w_wall_y = r_cur_y;
        case (w_dir)
            DIR_N:   w_wall_y = r_cur_y - YW'(1);
            DIR_E:   w_wall_x = r_cur_x + XW'(1);
            DIR_S:   w_wall_y = r_cur_y + YW'(1);
            DIR_W:   w_wall_x = r_cur_x - XW'(1);
            default: w_wall_x = r_cur_x;
        endcase
        w_tgt_x = r_cur_x;
        w_tgt_y = r_cur_y;
        case (r_dir)
            DIR_N:   w_tgt_y = r_cur_y - YW'(2);
            DIR_E:   w_tgt_x = r_cur_x + XW'(2);
            DIR_S:   w_tgt_y = r_cur_y + YW'(2);
            DIR_W:   w_tgt_x = r_cur_x - XW'(2);
            default: w_tgt_x = r_cur_x;
        endcase
    end

    assign w_fx_end       = ((LW'(r_fx) + L2) == w_cols);
    assign w_fy_end       = ((LW'(r_fy) + L2) == w_rows);
    assign w_cur_in_store = (w_xe < LW'(MAX_COLS)) && (w_ye < LW'(MAX_ROWS));
    assign w_full         = ((r_cnt + SCW'(1)) == SCW'(STACK_DEPTH));
    assign w_cnt_dec      = r_cnt - SCW'(1);

    assign w_cond = '{fill_empty:  (w_cols < L4) || (w_rows < L4),
                      fill_last:   w_fx_end && w_fy_end,
                      none_open:   w_none,
                      stack_empty: (r_cnt == '0),
                      out_free:    !r_out_valid || !i_out_stall};

    always_comb begin
        w_we = 1'b0;
        w_wa = '0;
        w_wd = CELL_ROOM;
        case (w_uw.act)
            A_FILL: begin
                w_we = 1'b1;
                w_wa = {r_fy, r_fx};
                w_wd = (r_fx[0] && r_fy[0]) ? CELL_OPEN : CELL_WALL;
            end
            A_MARK: begin
                w_we = w_cur_in_store;
                w_wa = {r_cur_y[RW-1:0], r_cur_x[CW-1:0]};
            end
            A_WALL: begin
                w_we = !w_none;
                w_wa = {w_wall_y[RW-1:0], w_wall_x[CW-1:0]};
            end
            A_CARVE: begin
                w_we = 1'b1;
                w_wa = {w_tgt_y[RW-1:0], w_tgt_x[CW-1:0]};
            end
            default: w_we = 1'b0;
        endcase
    end

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_walk   = r_walk;
        n_cnt    = r_cnt;
        n_fx     = r_fx;
        n_fy     = r_fy;
        n_dir    = r_dir;
        n_wall_x = r_wall_x;
        n_wall_y = r_wall_y;
        n_open2  = r_open2;
        n_rand   = r_rand;
        n_stat   = r_stat;
        if (w_go) begin
            n_rand   = i_rand_pick;
            n_wall_x = '0;
            n_wall_y = '0;
            if (!i_mode) begin
                n_cur_x = XW'(i_start_x);
                n_cur_y = YW'(i_start_y);
            end
        end
        case (w_uw.act)
            A_INIT: begin
                n_fx  = CW'(2);
                n_fy  = RW'(2);
                n_cnt = '0;
            end
            A_FILL: begin
                if (w_fx_end) begin
                    n_fx = CW'(2);
                    n_fy = r_fy + RW'(1);
                end else begin
                    n_fx = r_fx + CW'(1);
                end
            end
            A_MARK: n_walk = 1'b1;
            A_RDB: begin
                n_open2 = {w_ok[DIR_E] && (r_rd_b == CELL_OPEN),
                           w_ok[DIR_N] && (r_rd_a == CELL_OPEN)};
            end
            A_WALL: begin
                if (!w_none) begin
                    n_dir    = w_dir;
                    n_wall_x = w_wall_x;
                    n_wall_y = w_wall_y;
                end
            end
            A_CARVE: begin
                n_cur_x = w_tgt_x;
                n_cur_y = w_tgt_y;
                n_cnt   = r_cnt + SCW'(1);
                if (w_full) n_walk = 1'b0;
            end
            A_POPLD: begin
                n_cur_x = XW'(r_stk_rd[CW-1:0]);
                n_cur_y = YW'(r_stk_rd[MAW-1:CW]);
                n_cnt   = w_cnt_dec;
            end
            A_HALT: n_walk = 1'b0;
            default: n_walk = r_walk;
        endcase
        if (w_uw.set_stat) begin
            n_stat = ((w_uw.act == A_CARVE) && w_full) ? ST_OVERFLOW : w_uw.stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GRID_COLS_RST;
            r_grid_rows <= GRID_ROWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data[GROWS_W-1:0];
                default:       r_grid_cols <= r_grid_cols;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_walk      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_walk  <= n_walk;
            r_cnt   <= n_cnt;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fx     <= n_fx;
        r_fy     <= n_fy;
        r_dir    <= n_dir;
        r_wall_x <= n_wall_x;
        r_wall_y <= n_wall_y;
        r_open2  <= n_open2;
        r_rand   <= n_rand;
        r_stat   <= n_stat;
        if (w_emit) begin
            r_o_status <= n_stat;
            r_o_pos_x  <= n_cur_x[X_W-1:0];
            r_o_pos_y  <= n_cur_y[Y_W-1:0];
            r_o_wall_x <= n_wall_x[X_W-1:0];
            r_o_wall_y <= n_wall_y[Y_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cell_mem[w_wa] <= w_wd;
        end
        r_rd_a <= r_cell_mem[w_ra_a];
        r_rd_b <= r_cell_mem[w_ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.act == A_CARVE) begin
            r_stack_mem[r_cnt[SAW-1:0]] <= {w_tgt_y[RW-1:0], w_tgt_x[CW-1:0]};
        end
        if ((w_uw.act == A_POPRD) && (r_cnt != '0)) begin
            r_stk_rd <= r_stack_mem[w_cnt_dec[SAW-1:0]];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_pos_x     = r_o_pos_x;
    assign o_pos_y     = r_o_pos_y;
    assign o_wall_x    = r_o_wall_x;
    assign o_wall_y    = r_o_wall_y;

endmodule

FILE: hw/rtl/mcb_chk.sv
// Port-level checker for the maze carver and the bind that attaches it to the top level.
// Depends on mcb_pkg for field widths and status codes.
module mcb_chk
    import mcb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  i_mode,
    input logic [X_W-1:0]        i_start_x,
    input logic [Y_W-1:0]        i_start_y,
    input logic [RAND_W-1:0]     i_rand_pick,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [STAT_W-1:0]     o_status,
    input logic [X_W-1:0]        o_pos_x,
    input logic [Y_W-1:0]        o_pos_y,
    input logic [X_W-1:0]        o_wall_x,
    input logic [Y_W-1:0]        o_wall_y
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_wall_x) && $stable(o_wall_y))
        else $error("Stalled result changed or was dropped.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("A transaction was accepted while the previous one was still running.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_NOWALK))
        else $error("Result carries an undefined status code.");

    a_wall_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_CARVED) && (o_status != ST_OVERFLOW)
            |-> (o_wall_x == '0) && (o_wall_y == '0))
        else $error("Wall cell reported for a step that carved nothing.");

    a_wall_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == ST_CARVED) || (o_status == ST_OVERFLOW))
            |-> ((o_wall_x == o_pos_x)
                    && (((o_wall_y + 5'd1) == o_pos_y) || (o_wall_y == (o_pos_y + 5'd1))))
             || ((o_wall_y == o_pos_y)
                    && (((o_wall_x + 7'd1) == o_pos_x) || (o_wall_x == (o_pos_x + 7'd1)))))
        else $error("Carved wall cell is not next to the new position.");

endmodule

bind maze_carver_backtracker_unit mcb_chk u_mcb_chk (.*);
